[rtl/spm_pkg.sv]
// Shared constants, payload types and sequencer states of the sample playback mixer.
package spm_pkg;

	// Size of the design.
	localparam int CHANNELS = 16;
	localparam int RAM_WORDS = 65536;

	// Derived widths.
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CHAN_FIELD_W = 4;
	localparam int CHK_W = ((CH_W > CHAN_FIELD_W) ? CH_W : CHAN_FIELD_W) + 1;
	localparam int RA_W = $clog2(RAM_WORDS);
	localparam int START_W = 16;
	localparam int POS_W = 17;
	localparam int VOL_W = 9;
	localparam int SMP_W = 16;
	localparam int SUM_W = 18;
	localparam int DIV_W = SUM_W + 1;

	// Address reduction modulo the RAM size. A power-of-two size is a plain
	// truncation; other sizes below the span of start plus position need a
	// restoring shift-and-subtract over MOD_KMAX + 1 steps.
	localparam bit RAM_POW2 = (RAM_WORDS & (RAM_WORDS - 1)) == 0;
	localparam bit MOD_NEEDED = !RAM_POW2 && (RAM_WORDS < (2 ** SUM_W));
	localparam int MOD_KMAX = MOD_NEEDED ? (SUM_W - RA_W) : 0;
	localparam logic [DIV_W-1:0] DIV_TOP = DIV_W'(RAM_WORDS) << MOD_KMAX;
	localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(RAM_WORDS);

	// Operation codes.
	localparam logic [2:0] OP_WRITE = 3'd0;
	localparam logic [2:0] OP_LOAD = 3'd1;
	localparam logic [2:0] OP_PLAY = 3'd2;
	localparam logic [2:0] OP_STOP = 3'd3;
	localparam logic [2:0] OP_TICK = 3'd4;

	localparam logic [VOL_W-1:0] VOL_LOAD = 9'd255;

	typedef struct packed {
		logic [2:0] operation;
		logic [3:0] channel;
		logic [3:0] source_slot;
		logic [15:0] address;
		logic [16:0] sample_length;
		logic signed [15:0] sample_value;
		logic [8:0] gain;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
	} mix_t;

	typedef struct packed {
		logic [START_W-1:0] start_addr;
		logic [POS_W-1:0] count;
		logic [POS_W-1:0] pos;
		logic [VOL_W-1:0] vol;
	} desc_t;

	localparam int DESC_W = $bits(desc_t);

	typedef struct packed {
		logic clr;
		logic mul_en;
		logic acc_en;
	} mac_ctrl_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WR_MOD,
		S_PLAY_WR,
		S_T_SCAN,
		S_T_DESC,
		S_T_MOD,
		S_T_MUL,
		S_T_ACC,
		S_T_FIN
	} state_t;

endpackage

[rtl/sample_playback_mixer_core.sv]
// Top level of the sample playback mixer: command sequencer, channel flags and result register.

// The mixer takes one command transaction at a time and holds cmd_stall high until that
// command has finished. Writing a sample word folds the address and then writes the RAM,
// loading or stopping a slot is done as the command is taken, and starting playback reads
// the source descriptor and then writes the channel descriptor. A tick walks the sixteen
// channels in order through one shared descriptor memory port, one sample RAM read port and
// one multiplier: a silent channel is only scanned, a channel that reaches its end is
// scanned and has its descriptor read, and a sounding channel goes through scan, descriptor
// read, address fold, multiply and accumulate, and the tick ends by handing the frame to
// the result register. With a RAM size that is not a power of two the address fold runs a
// multi-step division for every write and every sounding channel. The result register lets
// a finished frame wait for mix_stall to fall while new commands are already being taken;
// only the next tick waits for it. Left and right always carry the same saturated sum.
// Unwritten sample RAM words read back as unspecified values; no pass clears them after reset.
module sample_playback_mixer_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  spm_pkg::cmd_t   cmd,
	output logic            mix_valid,
	input  logic            mix_stall,
	output spm_pkg::mix_t   mix
);

	spm_pkg::state_t state_q, state_d;
	spm_pkg::cmd_t   cmd_q;

	logic [spm_pkg::CH_W-1:0]     ch_q;
	logic [spm_pkg::CHANNELS-1:0] playing_q;
	logic [spm_pkg::CHANNELS-1:0] loaded_q;
	logic                         mix_valid_q;
	spm_pkg::mix_t                mix_q;

	// Decoded command fields.
	logic                         cmd_acc;
	logic [spm_pkg::CHK_W-1:0]    chan_ext, src_ext, qchan_ext, qsrc_ext;
	logic                         chan_ok, src_ok;
	logic [spm_pkg::CH_W-1:0]     chan_idx, src_idx, qchan_idx, qsrc_idx;
	logic                         ch_last, active, pos_end;

	// Sequencer outputs.
	logic                         desc_we, desc_re;
	logic [spm_pkg::CH_W-1:0]     desc_waddr, desc_raddr;
	spm_pkg::desc_t               desc_wdata, desc_rd;
	logic [spm_pkg::DESC_W-1:0]   desc_rdata;
	logic                         ram_we, ram_re;
	logic [spm_pkg::RA_W-1:0]     ram_addr;
	logic [spm_pkg::SMP_W-1:0]    ram_rdata;
	logic                         mod_start, mod_busy;
	logic [spm_pkg::SUM_W-1:0]    mod_value;
	logic [spm_pkg::RA_W-1:0]     mod_result;
	spm_pkg::mac_ctrl_t           mac_ctrl;
	logic signed [15:0]           mac_sum;
	logic                         ch_clr, ch_inc;
	logic [spm_pkg::CH_W-1:0]     flag_idx;
	logic                         pl_clr, pl_set, ld_we, ld_val;
	logic                         mix_load;

	assign cmd_stall = (state_q != spm_pkg::S_IDLE);
	assign cmd_acc = cmd_valid && !cmd_stall;

	// Channel numbers beyond the configured count make load, play and stop do nothing.
	assign chan_ext = spm_pkg::CHK_W'(cmd.channel);
	assign src_ext = spm_pkg::CHK_W'(cmd.source_slot);
	assign qchan_ext = spm_pkg::CHK_W'(cmd_q.channel);
	assign qsrc_ext = spm_pkg::CHK_W'(cmd_q.source_slot);
	assign chan_ok = chan_ext < spm_pkg::CHK_W'(spm_pkg::CHANNELS);
	assign src_ok = src_ext < spm_pkg::CHK_W'(spm_pkg::CHANNELS);
	assign chan_idx = chan_ext[spm_pkg::CH_W-1:0];
	assign src_idx = src_ext[spm_pkg::CH_W-1:0];
	assign qchan_idx = qchan_ext[spm_pkg::CH_W-1:0];
	assign qsrc_idx = qsrc_ext[spm_pkg::CH_W-1:0];

	assign desc_rd = spm_pkg::desc_t'(desc_rdata);
	assign ch_last = (ch_q == spm_pkg::CH_W'(spm_pkg::CHANNELS - 1));
	assign active = playing_q[ch_q] && loaded_q[ch_q];
	assign pos_end = (desc_rd.pos >= desc_rd.count);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spm_pkg::S_IDLE: begin
				if (cmd_acc) begin
					case (cmd.operation)
						spm_pkg::OP_WRITE: state_d = spm_pkg::S_WR_MOD;
						spm_pkg::OP_PLAY: begin
							if (chan_ok && src_ok) begin
								state_d = spm_pkg::S_PLAY_WR;
							end
						end
						spm_pkg::OP_TICK: state_d = spm_pkg::S_T_SCAN;
						default: state_d = spm_pkg::S_IDLE;
					endcase
				end
			end
			spm_pkg::S_WR_MOD: begin
				if (!mod_busy) begin
					state_d = spm_pkg::S_IDLE;
				end
			end
			spm_pkg::S_PLAY_WR: state_d = spm_pkg::S_IDLE;
			spm_pkg::S_T_SCAN: begin
				if (active) begin
					state_d = spm_pkg::S_T_DESC;
				end else if (ch_last) begin
					state_d = spm_pkg::S_T_FIN;
				end
			end
			spm_pkg::S_T_DESC: begin
				if (!pos_end) begin
					state_d = spm_pkg::S_T_MOD;
				end else if (ch_last) begin
					state_d = spm_pkg::S_T_FIN;
				end else begin
					state_d = spm_pkg::S_T_SCAN;
				end
			end
			spm_pkg::S_T_MOD: begin
				if (!mod_busy) begin
					state_d = spm_pkg::S_T_MUL;
				end
			end
			spm_pkg::S_T_MUL: state_d = spm_pkg::S_T_ACC;
			spm_pkg::S_T_ACC: state_d = ch_last ? spm_pkg::S_T_FIN : spm_pkg::S_T_SCAN;
			spm_pkg::S_T_FIN: begin
				if (!mix_valid_q || !mix_stall) begin
					state_d = spm_pkg::S_IDLE;
				end
			end
			default: state_d = spm_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		desc_we = 1'b0;
		desc_waddr = '0;
		desc_wdata = '0;
		desc_re = 1'b0;
		desc_raddr = ch_q;
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_addr = mod_result;
		mod_start = 1'b0;
		mod_value = spm_pkg::SUM_W'(desc_rd.start_addr) + spm_pkg::SUM_W'(desc_rd.pos);
		mac_ctrl = '0;
		ch_clr = 1'b0;
		ch_inc = 1'b0;
		flag_idx = ch_q;
		pl_clr = 1'b0;
		pl_set = 1'b0;
		ld_we = 1'b0;
		ld_val = 1'b0;
		mix_load = 1'b0;
		unique case (state_q)
			spm_pkg::S_IDLE: begin
				if (cmd_acc) begin
					case (cmd.operation)
						spm_pkg::OP_WRITE: begin
							mod_start = 1'b1;
							mod_value = spm_pkg::SUM_W'(cmd.address);
						end
						spm_pkg::OP_LOAD: begin
							if (chan_ok) begin
								desc_we = 1'b1;
								desc_waddr = chan_idx;
								desc_wdata.start_addr = cmd.address;
								desc_wdata.count = cmd.sample_length;
								desc_wdata.pos = '0;
								desc_wdata.vol = spm_pkg::VOL_LOAD;
								flag_idx = chan_idx;
								ld_we = 1'b1;
								ld_val = 1'b1;
								pl_clr = 1'b1;
							end
						end
						spm_pkg::OP_PLAY: begin
							if (chan_ok && src_ok) begin
								desc_re = 1'b1;
								desc_raddr = src_idx;
							end
						end
						spm_pkg::OP_STOP: begin
							if (chan_ok) begin
								flag_idx = chan_idx;
								pl_clr = 1'b1;
							end
						end
						spm_pkg::OP_TICK: begin
							mac_ctrl.clr = 1'b1;
							ch_clr = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			spm_pkg::S_WR_MOD: ram_we = !mod_busy;
			spm_pkg::S_PLAY_WR: begin
				desc_we = 1'b1;
				desc_waddr = qchan_idx;
				desc_wdata.start_addr = desc_rd.start_addr;
				desc_wdata.count = desc_rd.count;
				desc_wdata.pos = '0;
				desc_wdata.vol = cmd_q.gain;
				flag_idx = qchan_idx;
				ld_we = 1'b1;
				ld_val = loaded_q[qsrc_idx];
				pl_set = 1'b1;
			end
			spm_pkg::S_T_SCAN: begin
				desc_re = active;
				ch_inc = !active && !ch_last;
			end
			spm_pkg::S_T_DESC: begin
				if (pos_end) begin
					pl_clr = 1'b1;
					ch_inc = !ch_last;
				end else begin
					mod_start = 1'b1;
				end
			end
			spm_pkg::S_T_MOD: ram_re = !mod_busy;
			spm_pkg::S_T_MUL: mac_ctrl.mul_en = 1'b1;
			spm_pkg::S_T_ACC: begin
				mac_ctrl.acc_en = 1'b1;
				desc_we = 1'b1;
				desc_waddr = ch_q;
				desc_wdata = desc_rd;
				desc_wdata.pos = desc_rd.pos + spm_pkg::POS_W'(1);
				ch_inc = !ch_last;
			end
			spm_pkg::S_T_FIN: mix_load = !mix_valid_q || !mix_stall;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spm_pkg::S_IDLE;
			ch_q <= '0;
			playing_q <= '0;
			loaded_q <= '0;
			mix_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ch_clr) begin
				ch_q <= '0;
			end else if (ch_inc) begin
				ch_q <= ch_q + spm_pkg::CH_W'(1);
			end
			if (pl_clr) begin
				playing_q[flag_idx] <= 1'b0;
			end else if (pl_set) begin
				playing_q[flag_idx] <= 1'b1;
			end
			if (ld_we) begin
				loaded_q[flag_idx] <= ld_val;
			end
			if (mix_load) begin
				mix_valid_q <= 1'b1;
			end else if (!mix_stall) begin
				mix_valid_q <= 1'b0;
			end
		end
	end

	// Command and result payload.
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_q <= cmd;
		end
		if (mix_load) begin
			mix_q.left <= mac_sum;
			mix_q.right <= mac_sum;
		end
	end

	assign mix_valid = mix_valid_q;
	assign mix = mix_q;

	spm_ram #(
		.DEPTH(spm_pkg::CHANNELS),
		.WIDTH(spm_pkg::DESC_W)
	) u_desc_ram (
		.clk   (clk),
		.we    (desc_we),
		.waddr (desc_waddr),
		.wdata (desc_wdata),
		.re    (desc_re),
		.raddr (desc_raddr),
		.rdata (desc_rdata)
	);

	spm_ram #(
		.DEPTH(spm_pkg::RAM_WORDS),
		.WIDTH(spm_pkg::SMP_W)
	) u_sample_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (cmd_q.sample_value),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	spm_amod u_amod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  (mod_value),
		.busy   (mod_busy),
		.result (mod_result)
	);

	spm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.sample ($signed(ram_rdata)),
		.vol    (desc_rd.vol),
		.sum    (mac_sum)
	);

	// A frame only appears after the tick has walked every channel.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mix_valid) |-> $past(state_q == spm_pkg::S_T_FIN))
		else $error("frame presented outside the end of a tick");

	// The sample RAM is never touched while the address fold is still running.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we || ram_re) |-> !mod_busy)
		else $error("sample RAM accessed with an unfinished address");

	// Each accumulated channel moves the walk on by exactly one channel.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spm_pkg::S_T_ACC) && !ch_last |=>
		(ch_q == $past(ch_q) + spm_pkg::CH_W'(1)) && (state_q == spm_pkg::S_T_SCAN))
		else $error("channel walk skipped or repeated a channel");

endmodule

[rtl/spm_ram.sv]
// Generic single-write, single-read memory with a registered read port.
module spm_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/spm_amod.sv]
// Address reduction unit: folds a word address into the sample RAM range.
module spm_amod (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [spm_pkg::SUM_W-1:0] value,
	output logic                     busy,
	output logic [spm_pkg::RA_W-1:0]  result
);

	logic [spm_pkg::SUM_W-1:0] rem_q;
	logic [spm_pkg::DIV_W-1:0] div_q;
	logic                      busy_q;
	logic                      fits;

	// One restoring step per cycle against the shifted RAM size.
	assign fits = {1'b0, rem_q} >= div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= spm_pkg::MOD_NEEDED;
		end else if (busy_q && (div_q == spm_pkg::DIV_LAST)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			div_q <= spm_pkg::DIV_TOP;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= spm_pkg::SUM_W'({1'b0, rem_q} - div_q);
			end
			div_q <= div_q >> 1;
		end
	end

	assign busy = busy_q;
	assign result = spm_pkg::RA_W'(rem_q);

endmodule

[rtl/spm_mac.sv]
// Shared multiply, scale and saturating accumulate unit for the frame mix.
module spm_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spm_pkg::mac_ctrl_t            ctrl,
	input  logic signed [spm_pkg::SMP_W-1:0] sample,
	input  logic [spm_pkg::VOL_W-1:0]     vol,
	output logic signed [15:0]            sum
);

	localparam int PROD_W = spm_pkg::SMP_W + spm_pkg::VOL_W + 1;
	localparam int SCALE_W = PROD_W - 8;
	localparam int ACC_W = SCALE_W + 1;
	localparam int SAT_MIN = -32768;
	localparam int SAT_MAX = 32767;

	logic signed [PROD_W-1:0]  prod_s1;
	logic        [PROD_W-1:0]  prod_adj;
	logic signed [SCALE_W-1:0] scaled;
	logic signed [ACC_W-1:0]   total;
	logic signed [15:0]        sum_q;
	logic signed [15:0]        sum_d;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= sample * $signed({1'b0, vol});
		end
	end

	// Division by 256 rounds toward zero, so negative products are biased first.
	always_comb begin
		prod_adj = prod_s1[PROD_W-1] ? (prod_s1 + PROD_W'(255)) : prod_s1;
		scaled = prod_adj[PROD_W-1:8];
		total = ACC_W'(scaled) + ACC_W'(sum_q);
		if (total < SAT_MIN) begin
			sum_d = 16'sh8000;
		end else if (total > SAT_MAX) begin
			sum_d = 16'sh7fff;
		end else begin
			sum_d = total[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.clr) begin
			sum_q <= '0;
		end else if (ctrl.acc_en) begin
			sum_q <= sum_d;
		end
	end

	assign sum = sum_q;

endmodule
